@@ sv/lzrle_pkg.sv @@
// Shared types and constants for the LZ/RLE stream decompressor.
// Holds ring geometry, status and phase codes, and the queued operation record.
// Depends on nothing.
package lzrle_pkg;

	localparam int RING_AW    = 10;
	localparam int RING_DEPTH = 1 << RING_AW;

	typedef logic [RING_AW-1:0] ring_addr_t;

	typedef enum logic [1:0] {
		ST_ACCEPTED   = 2'd0,
		ST_BYTE       = 2'd1,
		ST_NEED_INPUT = 2'd2,
		ST_BUSY       = 2'd3
	} status_t;

	typedef enum logic [5:0] {
		PH_CMD    = 6'b000001,
		PH_COPYLO = 6'b000010,
		PH_LIT    = 6'b000100,
		PH_REPVAL = 6'b001000,
		PH_ZCOUNT = 6'b010000,
		PH_RUN    = 6'b100000
	} phase_t;

	typedef enum logic [1:0] {
		KIND_COPY = 2'd0,
		KIND_FILL = 2'd1,
		KIND_LIT  = 2'd2
	} kind_t;

	localparam logic [0:0] ACT_FEED = 1'b0;
	localparam logic [0:0] ACT_PULL = 1'b1;

	localparam logic [7:0] CMD_LIT_BASE  = 8'h80;
	localparam logic [7:0] CMD_REP_BASE  = 8'hA0;
	localparam logic [7:0] CMD_ZERO_BASE = 8'hE0;
	localparam logic [7:0] CMD_ZERO_EXT  = 8'hFF;
	localparam logic [8:0] RUN_BIAS      = 9'd2;

	// One decided transaction on its way to the byte engine.
	typedef struct packed {
		status_t    status;
		logic       eoc;
		logic       from_ring;
		logic       ring_valid;
		ring_addr_t raddr;
		ring_addr_t waddr;
		logic [7:0] value;
	} op_t;

	typedef struct packed {
		logic valid;
		op_t  op;
	} op_push_t;

endpackage

@@ sv/lzrle_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Read-first behavior on a same-address collision. Depends on nothing.
module lzrle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ sv/lzrle_front.sv @@
// Front end: accepts feed/pull transactions, runs the command decoder state,
// and emits one decided operation per transaction. Depends on lzrle_pkg.
module lzrle_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  in_action,
	input  logic [7:0]            in_byte,
	input  logic                  queue_full,
	output lzrle_pkg::op_push_t   push
);

	lzrle_pkg::phase_t     phase_q, phase_n;
	lzrle_pkg::kind_t      kind_q, kind_n;
	logic [8:0]            run_q, run_n, run_dec;
	lzrle_pkg::ring_addr_t dist_q, dist_n;
	lzrle_pkg::ring_addr_t wp_q, wp_n;
	logic                  wrapped_q, wrapped_n;
	logic [7:0]            rep_q, rep_n;
	logic [4:0]            lit_q, lit_n;
	lzrle_pkg::op_t        op;
	logic                  accept;

	assign in_ready = !queue_full;
	assign accept   = in_valid && !queue_full;
	assign run_dec  = run_q - 9'd1;

	always_comb begin
		phase_n   = phase_q;
		kind_n    = kind_q;
		run_n     = run_q;
		dist_n    = dist_q;
		wp_n      = wp_q;
		wrapped_n = wrapped_q;
		rep_n     = rep_q;
		lit_n     = lit_q;

		op.status     = lzrle_pkg::ST_ACCEPTED;
		op.eoc        = 1'b0;
		op.from_ring  = 1'b0;
		op.ring_valid = 1'b0;
		op.raddr      = wp_q - dist_q;
		op.waddr      = wp_q;
		op.value      = 8'd0;

		if (in_action == lzrle_pkg::ACT_FEED) begin
			if (phase_q == lzrle_pkg::PH_RUN) begin
				op.status = lzrle_pkg::ST_BUSY;
			end else begin
				case (phase_q)
					lzrle_pkg::PH_COPYLO: begin
						dist_n  = {dist_q[1:0], in_byte};
						kind_n  = lzrle_pkg::KIND_COPY;
						phase_n = lzrle_pkg::PH_RUN;
					end
					lzrle_pkg::PH_LIT: begin
						lit_n   = lit_q - 5'd1;
						rep_n   = in_byte;
						kind_n  = lzrle_pkg::KIND_LIT;
						run_n   = 9'd1;
						phase_n = lzrle_pkg::PH_RUN;
					end
					lzrle_pkg::PH_REPVAL: begin
						rep_n   = in_byte;
						kind_n  = lzrle_pkg::KIND_FILL;
						phase_n = lzrle_pkg::PH_RUN;
					end
					lzrle_pkg::PH_ZCOUNT: begin
						rep_n   = 8'd0;
						kind_n  = lzrle_pkg::KIND_FILL;
						run_n   = {1'b0, in_byte} + lzrle_pkg::RUN_BIAS;
						phase_n = lzrle_pkg::PH_RUN;
					end
					default: begin
						// command byte; unused phase codes land here too
						if (in_byte < lzrle_pkg::CMD_LIT_BASE) begin
							dist_n  = {8'd0, in_byte[1:0]};
							run_n   = {4'd0, in_byte[6:2]} + lzrle_pkg::RUN_BIAS;
							phase_n = lzrle_pkg::PH_COPYLO;
						end else if (in_byte < lzrle_pkg::CMD_REP_BASE) begin
							lit_n   = in_byte[4:0];
							phase_n = (in_byte[4:0] != 5'd0) ? lzrle_pkg::PH_LIT
							                                 : lzrle_pkg::PH_CMD;
						end else if (in_byte < lzrle_pkg::CMD_ZERO_BASE) begin
							run_n   = {4'd0, in_byte[4:0]} + lzrle_pkg::RUN_BIAS;
							phase_n = lzrle_pkg::PH_REPVAL;
						end else if (in_byte != lzrle_pkg::CMD_ZERO_EXT) begin
							rep_n   = 8'd0;
							kind_n  = lzrle_pkg::KIND_FILL;
							run_n   = {4'd0, in_byte[4:0]} + lzrle_pkg::RUN_BIAS;
							phase_n = lzrle_pkg::PH_RUN;
						end else begin
							phase_n = lzrle_pkg::PH_ZCOUNT;
						end
					end
				endcase
			end
		end else if (phase_q != lzrle_pkg::PH_RUN || run_q == 9'd0) begin
			op.status = lzrle_pkg::ST_NEED_INPUT;
		end else begin
			op.status     = lzrle_pkg::ST_BYTE;
			op.from_ring  = (kind_q == lzrle_pkg::KIND_COPY);
			op.value      = (kind_q == lzrle_pkg::KIND_COPY) ? 8'd0 : rep_q;
			// entries below the write pointer, or all once wrapped, hold real data
			op.ring_valid = wrapped_q || (op.raddr < wp_q);
			wp_n          = wp_q + 1'b1;
			wrapped_n     = wrapped_q || (wp_q == '1);
			run_n         = run_dec;
			if (run_dec == 9'd0) begin
				if (kind_q == lzrle_pkg::KIND_LIT && lit_q != 5'd0) begin
					phase_n = lzrle_pkg::PH_LIT;
				end else begin
					phase_n = lzrle_pkg::PH_CMD;
					op.eoc  = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= lzrle_pkg::PH_CMD;
			kind_q    <= lzrle_pkg::KIND_COPY;
			run_q     <= 9'd0;
			dist_q    <= '0;
			wp_q      <= '0;
			wrapped_q <= 1'b0;
			rep_q     <= 8'd0;
			lit_q     <= 5'd0;
		end else if (accept) begin
			phase_q   <= phase_n;
			kind_q    <= kind_n;
			run_q     <= run_n;
			dist_q    <= dist_n;
			wp_q      <= wp_n;
			wrapped_q <= wrapped_n;
			rep_q     <= rep_n;
			lit_q     <= lit_n;
		end
	end

	assign push.valid = accept;
	assign push.op    = op;

endmodule

@@ sv/lzrle_fifo.sv @@
// Short operation queue between the decoder front end and the byte engine.
// Depends on lzrle_pkg for the operation record.
module lzrle_fifo #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lzrle_pkg::op_push_t push,
	output logic                full,
	output logic                deq_valid,
	output lzrle_pkg::op_t      deq_op,
	input  logic                deq_ready
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	lzrle_pkg::op_t mem_q [DEPTH];
	logic [IW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_pop;

	assign full      = (count_q == CW'(DEPTH));
	assign deq_valid = (count_q != '0);
	assign deq_op    = mem_q[rd_ptr_q];
	assign do_pop    = deq_valid && deq_ready;

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= (wr_ptr_q == IW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == IW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push.valid && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push.valid && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ sv/lzrle_back.sv @@
// Byte engine: reads the history ring, forms each output byte, writes it back
// and holds the result in the output register. Depends on lzrle_pkg, lzrle_ram.
module lzrle_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           deq_valid,
	input  lzrle_pkg::op_t deq_op,
	output logic           deq_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [1:0]     out_status,
	output logic [7:0]     out_byte,
	output logic           out_eoc
);

	logic           op_valid_s1;
	lzrle_pkg::op_t op_s1;
	logic           fwd_s1;
	logic [7:0]     fwd_byte_s1;
	logic [7:0]     rd_data;
	logic [7:0]     byte_s1;
	logic           move_s1, wr_en, pop;

	logic       out_valid_q, out_eoc_q;
	logic [1:0] out_status_q;
	logic [7:0] out_byte_q;

	assign move_s1   = op_valid_s1 && (!out_valid_q || out_ready);
	assign pop       = deq_valid && (!op_valid_s1 || move_s1);
	assign deq_ready = !op_valid_s1 || move_s1;
	assign wr_en     = move_s1 && (op_s1.status == lzrle_pkg::ST_BYTE);

	always_comb begin
		if (!op_s1.from_ring) begin
			byte_s1 = op_s1.value;
		end else if (fwd_s1) begin
			byte_s1 = fwd_byte_s1;
		end else if (op_s1.ring_valid) begin
			byte_s1 = rd_data;
		end else begin
			byte_s1 = 8'd0;
		end
	end

	lzrle_ram #(
		.WIDTH(8),
		.DEPTH(lzrle_pkg::RING_DEPTH)
	) u_ring (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(op_s1.waddr),
		.wr_data(byte_s1),
		.rd_en  (pop),
		.rd_addr(deq_op.raddr),
		.rd_data(rd_data)
	);

	// bypass the byte being written in the same cycle as the read is issued
	always_ff @(posedge clk) begin
		if (pop) begin
			op_s1       <= deq_op;
			fwd_s1      <= wr_en && (op_s1.waddr == deq_op.raddr);
			fwd_byte_s1 <= byte_s1;
		end
		if (move_s1) begin
			out_status_q <= op_s1.status;
			out_byte_q   <= byte_s1;
			out_eoc_q    <= op_s1.eoc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				op_valid_s1 <= 1'b1;
			end else if (move_s1) begin
				op_valid_s1 <= 1'b0;
			end
			if (move_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_byte   = out_byte_q;
	assign out_eoc    = out_eoc_q;

endmodule

@@ sv/lz_rle_stream_decompressor_core.sv @@
// Path: each accepted transaction passes the queue, the stage-1 register and the output
//   register before its result shows on the master side with m_axis_tvalid.
// Throughput: one transaction per cycle, feeds and pulls alike, while m_axis_tready stays
//   high; set by the single ring read and write per cycle in the byte engine.
// Reset (arst_n low, asynchronous): decoder awaits a command byte, queue and output
//   empty; the history ring reads as zeros until written, tracked by the write pointer.
module lz_rle_stream_decompressor_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// slave side
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic        s_axis_tuser,  // [0] action: 0 feed, 1 pull
	// master side
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // [7:0] out_byte
	output logic [1:0]  m_axis_tuser,  // [1:0] status: 0 accepted, 1 byte, 2 needs input, 3 busy
	output logic        m_axis_tlast   // end_of_command
);

	lzrle_pkg::op_push_t push;
	logic                q_full;
	logic                q_valid;
	lzrle_pkg::op_t      q_op;
	logic                q_ready;
	logic [1:0]          res_status;
	logic [7:0]          res_byte;

	// Decode every transaction up front; the decision is final once accepted.
	lzrle_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_action (s_axis_tuser),
		.in_byte   (s_axis_tdata),
		.queue_full(q_full),
		.push      (push)
	);

	// Buffer decided operations so the front end keeps accepting while the
	// master side stalls, until the queue is full.
	lzrle_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (q_full),
		.deq_valid(q_valid),
		.deq_op   (q_op),
		.deq_ready(q_ready)
	);

	// Produce bytes in order and advance the history ring.
	lzrle_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.deq_valid (q_valid),
		.deq_op    (q_op),
		.deq_ready (q_ready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_status(res_status),
		.out_byte  (res_byte),
		.out_eoc   (m_axis_tlast)
	);

	assign m_axis_tdata = res_byte;
	assign m_axis_tuser = res_status;

	// end of command is only flagged on a delivered byte
	a_last_on_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> res_status == lzrle_pkg::ST_BYTE)
		else $error("tlast without a byte");

	// non-byte results carry a zero byte
	a_zero_when_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res_status != lzrle_pkg::ST_BYTE |-> res_byte == 8'd0)
		else $error("nonzero byte on a non-byte result");

	// backpressure on the slave side only comes from a loaded queue
	a_stall_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> q_valid)
		else $error("slave side stalled with an empty queue");

endmodule

@@ tb/sv/lzrle_result_checker.sv @@
// Result checker for the LZ/RLE stream decompressor testbench.
// Decodes every accepted input transaction itself and checks each output transaction
// against the oldest predicted result. Depends on lzrle_pkg.
module lzrle_result_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	input  logic        s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [7:0]  m_axis_tdata,
	input  logic [1:0]  m_axis_tuser,
	input  logic        m_axis_tlast,
	output int          mismatches,
	output int          owed,
	output logic        at_command,
	output logic        run_active
);

	typedef struct {
		lzrle_pkg::status_t status;
		logic [7:0]         value;
		logic               last;
	} decoded_t;

	// Private copy of the decoder state.
	logic [7:0]            history [lzrle_pkg::RING_DEPTH];
	lzrle_pkg::ring_addr_t wr_ptr;
	lzrle_pkg::phase_t     phase;
	lzrle_pkg::kind_t      kind;
	logic [8:0]            run_left;
	lzrle_pkg::ring_addr_t distance;
	logic [7:0]            fill_value;
	logic [4:0]            literals_left;

	decoded_t   owed_q[$];
	int         err_count;

	task automatic begin_run(input lzrle_pkg::kind_t k, input logic [8:0] len);
		kind = k;
		run_left = len;
		phase = lzrle_pkg::PH_RUN;
	endtask

	// Consume one compressed byte in the current phase.
	task automatic take_byte(input logic [7:0] b);
		case (phase)
		lzrle_pkg::PH_COPYLO: begin
			distance = {distance[1:0], b};
			begin_run(lzrle_pkg::KIND_COPY, run_left);
		end
		lzrle_pkg::PH_LIT: begin
			literals_left = literals_left - 5'd1;
			fill_value = b;
			begin_run(lzrle_pkg::KIND_LIT, 9'd1);
		end
		lzrle_pkg::PH_REPVAL: begin
			fill_value = b;
			begin_run(lzrle_pkg::KIND_FILL, run_left);
		end
		lzrle_pkg::PH_ZCOUNT: begin
			fill_value = '0;
			begin_run(lzrle_pkg::KIND_FILL, {1'b0, b} + lzrle_pkg::RUN_BIAS);
		end
		default: begin
			if (b < lzrle_pkg::CMD_LIT_BASE) begin
				distance = lzrle_pkg::ring_addr_t'(b[1:0]);
				run_left = {4'b0, b[6:2]} + lzrle_pkg::RUN_BIAS;
				phase = lzrle_pkg::PH_COPYLO;
			end else if (b < lzrle_pkg::CMD_REP_BASE) begin
				literals_left = b[4:0];
				if (b[4:0] != 5'd0)
					phase = lzrle_pkg::PH_LIT;
				else
					phase = lzrle_pkg::PH_CMD;
			end else if (b < lzrle_pkg::CMD_ZERO_BASE) begin
				run_left = {4'b0, b[4:0]} + lzrle_pkg::RUN_BIAS;
				phase = lzrle_pkg::PH_REPVAL;
			end else if (b != lzrle_pkg::CMD_ZERO_EXT) begin
				fill_value = '0;
				begin_run(lzrle_pkg::KIND_FILL, {4'b0, b[4:0]} + lzrle_pkg::RUN_BIAS);
			end else begin
				phase = lzrle_pkg::PH_ZCOUNT;
			end
		end
		endcase
	endtask

	// Work out the result of one input transaction and queue it.
	task automatic decode_item(input logic act, input logic [7:0] b);
		decoded_t              r;
		lzrle_pkg::ring_addr_t rd_addr;
		r.status = lzrle_pkg::ST_ACCEPTED;
		r.value = '0;
		r.last = 1'b0;
		if (act == lzrle_pkg::ACT_FEED) begin
			if (phase == lzrle_pkg::PH_RUN)
				r.status = lzrle_pkg::ST_BUSY;
			else
				take_byte(b);
		end else if (phase != lzrle_pkg::PH_RUN || run_left == '0) begin
			r.status = lzrle_pkg::ST_NEED_INPUT;
		end else begin
			rd_addr = wr_ptr - distance;
			if (kind == lzrle_pkg::KIND_COPY)
				r.value = history[rd_addr];
			else
				r.value = fill_value;
			history[wr_ptr] = r.value;
			wr_ptr = wr_ptr + 1'b1;
			run_left = run_left - 1'b1;
			r.status = lzrle_pkg::ST_BYTE;
			if (run_left == '0) begin
				if (kind == lzrle_pkg::KIND_LIT && literals_left != '0) begin
					phase = lzrle_pkg::PH_LIT;
				end else begin
					phase = lzrle_pkg::PH_CMD;
					r.last = 1'b1;
				end
			end
		end
		owed_q = {owed_q, r};
	endtask

	always @(posedge clk or negedge arst_n) begin
		decoded_t want;
		if (!arst_n) begin
			for (int i = 0; i < lzrle_pkg::RING_DEPTH; i++)
				history[i] = '0;
			wr_ptr = '0;
			phase = lzrle_pkg::PH_CMD;
			kind = lzrle_pkg::KIND_COPY;
			run_left = '0;
			distance = '0;
			fill_value = '0;
			literals_left = '0;
			owed_q.delete();
			err_count = 0;
		end else begin
			// Check the output first: it always belongs to an older input.
			if (m_axis_tvalid && m_axis_tready) begin
				if (owed_q.size() == 0) begin
					err_count++;
					$display("%0t: unexpected result, got status %0d byte %02h last %0b",
						$time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
				end else begin
					want = owed_q.pop_front();
					if (m_axis_tuser !== want.status || m_axis_tdata !== want.value ||
					    m_axis_tlast !== want.last) begin
						err_count++;
						$display("%0t: exp st %0d byte %02h last %0b, got st %0d byte %02h last %0b",
							$time, want.status, want.value, want.last,
							m_axis_tuser, m_axis_tdata, m_axis_tlast);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				decode_item(s_axis_tuser, s_axis_tdata);
		end
		mismatches <= err_count;
		owed <= owed_q.size();
		at_command <= (phase == lzrle_pkg::PH_CMD);
		run_active <= (phase == lzrle_pkg::PH_RUN);
	end

endmodule

@@ tb/sv/tb_lz_rle_stream_decompressor_core.sv @@
// Testbench top for lz_rle_stream_decompressor_core: clock, reset, stimulus and verdict.
// Checking is done by lzrle_result_checker. Depends on lzrle_pkg and the core.
module tb_lz_rle_stream_decompressor_core;

	localparam int ITEMS = 1150;
	localparam int LIMIT = 600000;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	int          mismatches;
	int          owed;
	logic        at_command;
	logic        run_active;

	int          counted = 0;   // input transactions sent so far
	logic        steady = 1'b0; // suppress input gaps for the current stretch
	int          cycles = 0;

	lz_rle_stream_decompressor_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	lzrle_result_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.mismatches    (mismatches),
		.owed          (owed),
		.at_command    (at_command),
		.run_active    (run_active)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog: end the run if the stimulus or the drain hangs.
	initial begin
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAIL");
		$finish;
	end

	// Input gap length: mostly back to back, some short gaps, rare long ones.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Drive one transaction and hold it until accepted. Valid stays high on return so
	// the next transaction can follow in the very next cycle; a gap lowers it first.
	task automatic send_item(input logic act, input logic [7:0] b);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= act;
		s_axis_tdata <= b;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		counted++;
	endtask

	task automatic feed(input logic [7:0] b);
		send_item(lzrle_pkg::ACT_FEED, b);
	endtask

	// Pull carries a random data byte that the block must ignore.
	task automatic pull();
		send_item(lzrle_pkg::ACT_PULL, 8'($urandom_range(0, 255)));
	endtask

	// Pull a whole run, now and then slipping in a feed that must come back busy.
	task automatic drain_run(input int len);
		repeat (len) begin
			if ($urandom_range(0, 19) == 0)
				send_item(lzrle_pkg::ACT_FEED, 8'($urandom_range(0, 255)));
			pull();
		end
	endtask

	// One well-formed command with random content, followed by all its pulls.
	task automatic play_command();
		logic [7:0] cmd;
		logic [7:0] arg;
		cmd = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 99) < 8)
			cmd = lzrle_pkg::CMD_ZERO_EXT;
		if (cmd < lzrle_pkg::CMD_LIT_BASE) begin
			arg = 8'($urandom_range(0, 255));
			// bias toward distance zero: the slot about to be overwritten
			if ($urandom_range(0, 9) == 0) begin
				cmd[1:0] = 2'b00;
				arg = '0;
			end
			feed(cmd);
			feed(arg);
			drain_run(int'(cmd[6:2]) + 2);
		end else if (cmd < lzrle_pkg::CMD_REP_BASE) begin
			feed(cmd);
			repeat (cmd[4:0]) begin
				feed(8'($urandom_range(0, 255)));
				drain_run(1);
			end
		end else if (cmd < lzrle_pkg::CMD_ZERO_BASE) begin
			feed(cmd);
			feed(8'($urandom_range(0, 255)));
			drain_run(int'(cmd[4:0]) + 2);
		end else if (cmd != lzrle_pkg::CMD_ZERO_EXT) begin
			feed(cmd);
			drain_run(int'(cmd[4:0]) + 2);
		end else begin
			// keep extended zero runs mostly short
			if ($urandom_range(0, 4) == 0)
				arg = 8'($urandom_range(0, 255));
			else
				arg = 8'($urandom_range(0, 15));
			feed(cmd);
			feed(arg);
			drain_run(int'(arg) + 2);
		end
		// stray pull with nothing pending
		if ($urandom_range(0, 19) == 0)
			pull();
	endtask

	// Burst of fully random transactions, then walk the decoder back to a command
	// boundary. Lower valid and wait on the clock after each step so the checker's
	// phase flags are settled when read.
	task automatic scramble();
		repeat ($urandom_range(1, 6))
			send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (!at_command) begin
			if (run_active)
				pull();
			else
				feed(8'($urandom_range(0, 15)));
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Output back-pressure: ready windows of varying length, mostly short stalls.
	initial begin
		int hold;
		int stall;
		forever begin
			if ($urandom_range(0, 4) == 0)
				hold = $urandom_range(100, 300);
			else
				hold = $urandom_range(1, 30);
			m_axis_tready <= 1'b1;
			repeat (hold) @(posedge clk);
			stall = $urandom_range(0, 99);
			if (stall < 80)
				stall = $urandom_range(1, 3);
			else if (stall < 95)
				stall = $urandom_range(4, 10);
			else
				stall = $urandom_range(20, 60);
			m_axis_tready <= 1'b0;
			repeat (stall) @(posedge clk);
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Pull straight after reset: nothing pending.
		pull();
		// Copy at distance zero before any write: reads the cleared ring.
		feed(8'h00);
		feed(8'h00);
		pull();
		pull();
		// Literal command with a zero count yields nothing.
		feed(lzrle_pkg::CMD_LIT_BASE);
		// Two literals; a feed while one is pending is dropped.
		feed(lzrle_pkg::CMD_LIT_BASE | 8'h02);
		feed(8'hFF);
		feed(8'h5A);
		pull();
		feed(8'h00);
		pull();
		// Shortest repeat run.
		feed(lzrle_pkg::CMD_REP_BASE);
		feed(8'hAB);
		pull();
		pull();
		// Shortest zero run.
		feed(lzrle_pkg::CMD_ZERO_BASE);
		pull();
		pull();
		// Extended zero run with count byte zero.
		feed(lzrle_pkg::CMD_ZERO_EXT);
		feed(8'h00);
		pull();
		pull();
		// Overlapping copy at distance one.
		feed(8'h00);
		feed(8'h01);
		pull();
		pull();

		counted = 0;
		while (counted < ITEMS) begin
			steady = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 99) < 85)
				play_command();
			else
				scramble();
		end

		// Drop valid and let the checker catch up before polling the owed count.
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (owed != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		if (mismatches == 0 && owed == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
